// ===== hdl/rpa_pkg.sv =====
// Shared types and constants for the register pool allocator.
`timescale 1ns / 1ps
package rpa_pkg;

    localparam int ID_W = 16;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_RESET  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_CONST = 2'd0,
        KIND_TEMP  = 2'd1,
        KIND_PARAM = 2'd2,
        KIND_VAR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        POOL_TEMP  = 2'd0,
        POOL_PARAM = 2'd1,
        POOL_SAVED = 2'd2
    } pool_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PARAM_EX = 2'd1,
        ST_NO_EVICT = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [ID_W-1:0] var_id;
        logic [1:0]      operand_kind;
    } in_item_t;

    typedef struct packed {
        logic [1:0]      status;
        logic            found;
        logic [1:0]      reg_class;
        logic [3:0]      reg_index;
        logic            spilled;
        logic [ID_W-1:0] spill_var;
    } out_item_t;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        logic [1:0]      opcode;
        logic [ID_W-1:0] var_id;
        logic [1:0]      pool;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_SEARCH = 2'd1,
        BK_EXEC   = 2'd2,
        BK_OUT    = 2'd3
    } bk_state_t;

endpackage

// ===== hdl/rpa_front.sv =====
// Front end: accepts input beats, maps operand kind to a pool, feeds a two-entry queue.
`timescale 1ns / 1ps
module rpa_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rpa_pkg::in_item_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output rpa_pkg::cmd_t     cmd_data
);
    import rpa_pkg::*;

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       cls;
    logic       push, pop;

    // Pool selection: constant and temp share the temp pool.
    always_comb
    begin
        cls.opcode = in_data.opcode;
        cls.var_id = in_data.var_id;
        unique case (kind_t'(in_data.operand_kind))
            KIND_CONST, KIND_TEMP: cls.pool = POOL_TEMP;
            KIND_PARAM:            cls.pool = POOL_PARAM;
            default:               cls.pool = POOL_SAVED;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_data  = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= cls;
    end
endmodule

// ===== hdl/rpa_back.sv =====
// Back end: binding table search, free FIFOs, age queues and result register.
`timescale 1ns / 1ps
module rpa_back #(
    parameter int TEMP_REGS   = 7,
    parameter int PARAM_REGS  = 8,
    parameter int SAVED_REGS  = 11,
    parameter int VAR_ID_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  rpa_pkg::cmd_t      cmd_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rpa_pkg::out_item_t out_data
);
    import rpa_pkg::*;

    localparam int NSLOTS = TEMP_REGS + PARAM_REGS + SAVED_REGS;
    localparam int SW     = $clog2(NSLOTS + 1);
    localparam int NP     = 3;
    localparam int MAXP   = 16;

    // Pool geometry as vectors so the pool code selects it.
    logic [4:0] psize [NP];
    logic [SW-1:0] pbase [NP];
    assign psize[0] = 5'(TEMP_REGS);
    assign psize[1] = 5'(PARAM_REGS);
    assign psize[2] = 5'(SAVED_REGS);
    assign pbase[0] = SW'(0);
    assign pbase[1] = SW'(TEMP_REGS);
    assign pbase[2] = SW'(TEMP_REGS + PARAM_REGS);

    // Per-pool queues, kept as shifting register rows.
    logic [3:0] fq_reg [NP][MAXP];
    logic [3:0] fq_next [NP][MAXP];
    logic [4:0] fn_reg [NP], fn_next [NP];
    logic [3:0] aq_reg [NP][MAXP];
    logic [3:0] aq_next [NP][MAXP];
    logic [4:0] an_reg [NP], an_next [NP];
    logic [VAR_ID_BITS-1:0] own_reg [NSLOTS];
    logic [NSLOTS-1:0]      sv_reg, sv_next;

    bk_state_t st_reg, st_next;
    cmd_t      cmd_reg;
    logic      hit_reg;
    logic [SW-1:0] hslot_reg;
    out_item_t res_reg, res_next;
    logic      ov_reg, ov_next;

    logic [VAR_ID_BITS-1:0] cid;
    logic [NSLOTS-1:0]      match;
    logic                   hit;
    logic [SW-1:0]          hslot;
    logic                   own_we;
    logic [SW-1:0]          own_slot;

    assign cid = VAR_ID_BITS'(cmd_reg.var_id);

    // Parallel compare against all bound slots, priority to the lowest.
    always_comb
    begin
        hit   = 1'b0;
        hslot = '0;
        for (int s = 0; s < NSLOTS; s++)
            match[s] = sv_reg[s] && (own_reg[s] == cid);
        for (int s = NSLOTS - 1; s >= 0; s--)
            if (match[s])
            begin
                hit   = 1'b1;
                hslot = SW'(s);
            end
    end

    assign cmd_ready = (st_reg == BK_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = res_reg;

    // Sequencer: take a command, search, execute, hold the result.
    // Execution waits while the previous result beat is still unclaimed.
    always_comb
    begin
        logic [1:0] p;
        logic [3:0] r;
        logic [1:0] hp;
        logic [SW-1:0] t;
        logic       rm;
        st_next  = st_reg;
        res_next = res_reg;
        ov_next  = ov_reg;
        sv_next  = sv_reg;
        fq_next  = fq_reg;
        fn_next  = fn_reg;
        aq_next  = aq_reg;
        an_next  = an_reg;
        own_we   = 1'b0;
        own_slot = '0;
        p  = cmd_reg.pool;
        r  = '0;
        t  = '0;
        rm = 1'b0;
        hp = (hslot_reg < pbase[1]) ? 2'd0 : ((hslot_reg < pbase[2]) ? 2'd1 : 2'd2);
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (st_reg)
            BK_IDLE:
                if (cmd_valid)
                    st_next = BK_SEARCH;
            BK_SEARCH:
                st_next = BK_EXEC;
            BK_EXEC:
                if (!ov_reg || out_ready)
                begin
                    res_next = '0;
                    st_next  = BK_OUT;
                    unique case (op_t'(cmd_reg.opcode))
                        OP_ALLOC:
                            if (hit_reg)
                            begin
                                res_next.found     = 1'b1;
                                res_next.reg_class = hp;
                                res_next.reg_index = 4'(hslot_reg - pbase[hp]);
                            end
                            else if (fn_reg[p] != 5'd0)
                            begin
                                r = fq_reg[p][0];
                                for (int i = 0; i < MAXP - 1; i++)
                                    fq_next[p][i] = fq_reg[p][i+1];
                                fn_next[p] = fn_reg[p] - 5'd1;
                                t = pbase[p] + SW'(r);
                                own_we = 1'b1;
                                own_slot = t;
                                sv_next[t] = 1'b1;
                                aq_next[p][an_reg[p][3:0]] = r;
                                an_next[p] = an_reg[p] + 5'd1;
                                res_next.reg_class = p;
                                res_next.reg_index = r;
                            end
                            else if (p == POOL_PARAM)
                                res_next.status = ST_PARAM_EX;
                            else if (an_reg[p] == 5'd0)
                                res_next.status = ST_NO_EVICT;
                            else
                            begin
                                // Rotate oldest to the back and rebind it.
                                r = aq_reg[p][0];
                                for (int i = 0; i < MAXP - 1; i++)
                                    aq_next[p][i] = aq_reg[p][i+1];
                                aq_next[p][an_reg[p][3:0] - 4'd1] = r;
                                t = pbase[p] + SW'(r);
                                res_next.spilled   = 1'b1;
                                res_next.spill_var = ID_W'(own_reg[t]);
                                own_we = 1'b1;
                                own_slot = t;
                                sv_next[t] = 1'b1;
                                res_next.reg_class = p;
                                res_next.reg_index = r;
                            end
                        OP_FREE:
                            if (hit_reg)
                            begin
                                r = 4'(hslot_reg - pbase[hp]);
                                for (int i = 0; i < MAXP; i++)
                                begin
                                    if (5'(i) < an_reg[hp] && aq_reg[hp][i] == r)
                                        rm = 1'b1;
                                    if (rm && i < MAXP - 1)
                                        aq_next[hp][i] = aq_reg[hp][i+1];
                                end
                                if (rm)
                                    an_next[hp] = an_reg[hp] - 5'd1;
                                if (fn_reg[hp] < 5'(MAXP))
                                begin
                                    fq_next[hp][fn_reg[hp][3:0]] = r;
                                    fn_next[hp] = fn_reg[hp] + 5'd1;
                                end
                                sv_next[hslot_reg] = 1'b0;
                                res_next.found     = 1'b1;
                                res_next.reg_class = hp;
                                res_next.reg_index = r;
                            end
                        OP_LOOKUP:
                            if (hit_reg)
                            begin
                                res_next.found     = 1'b1;
                                res_next.reg_class = hp;
                                res_next.reg_index = 4'(hslot_reg - pbase[hp]);
                            end
                        default:
                        begin
                            sv_next = '0;
                            for (int q = 0; q < NP; q++)
                            begin
                                for (int i = 0; i < MAXP; i++)
                                    fq_next[q][i] = 4'(i);
                                fn_next[q] = psize[q];
                                an_next[q] = 5'd0;
                            end
                        end
                    endcase
                end
            default:
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    st_next = BK_IDLE;
                end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_IDLE;
            ov_reg <= 1'b0;
            sv_reg <= '0;
            for (int q = 0; q < NP; q++)
            begin
                for (int i = 0; i < MAXP; i++)
                    fq_reg[q][i] <= 4'(i);
                fn_reg[q] <= psize[q];
                an_reg[q] <= 5'd0;
            end
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            sv_reg <= sv_next;
            fq_reg <= fq_next;
            fn_reg <= fn_next;
            an_reg <= an_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (st_reg == BK_IDLE && cmd_valid)
            cmd_reg <= cmd_data;
        if (st_reg == BK_SEARCH)
        begin
            hit_reg   <= hit;
            hslot_reg <= hslot;
        end
        if (own_we)
            own_reg[own_slot] <= cid;
        aq_reg  <= aq_next;
        res_reg <= res_next;
    end
endmodule

// ===== hdl/register_pool_allocator_fifo_evict.sv =====
// Top level of the register pool allocator with FIFO eviction.
//
// Input channel in_valid/in_ready carries one command beat (opcode, var_id,
// operand_kind); output channel out_valid/out_ready carries one result beat
// per command, in order. A front end classifies commands into a two-entry
// queue; the back end runs each through take, search, execute and output
// steps. A result becomes valid once its command has passed the front queue
// register and then those back-end steps in order. The back end takes a
// new command only after the result of the previous one is registered.
// The front queue keeps accepting while a result waits to be taken.
// Reset puts every free FIFO at its full index list, empties the age
// queues and clears all bindings. A stalled receiver holds the result
// register; the back end then waits in its execute step and the front
// queue fills and drops in_ready.
`timescale 1ns / 1ps
module register_pool_allocator_fifo_evict #(
    parameter int TEMP_REGS   = 7,
    parameter int PARAM_REGS  = 8,
    parameter int SAVED_REGS  = 11,
    parameter int VAR_ID_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rpa_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rpa_pkg::out_item_t out_data
);
    import rpa_pkg::*;

    logic cmd_valid, cmd_ready;
    cmd_t cmd_data;

    rpa_front u_front (
        .clk, .rst_n, .in_valid, .in_ready, .in_data,
        .cmd_valid, .cmd_ready, .cmd_data
    );

    rpa_back #(
        .TEMP_REGS(TEMP_REGS), .PARAM_REGS(PARAM_REGS),
        .SAVED_REGS(SAVED_REGS), .VAR_ID_BITS(VAR_ID_BITS)
    ) u_back (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd_data,
        .out_valid, .out_ready, .out_data
    );
endmodule

// ===== hdl/rpa_checker.sv =====
// Port-level checks for the register pool allocator.
`timescale 1ns / 1ps
module rpa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input rpa_pkg::out_item_t out_data
);
    import rpa_pkg::*;

    // A stalled result beat stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");

    // A waiting command beat is not withdrawn.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("command withdrawn before acceptance");

    // Spill only comes with a clean ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.spilled |-> out_data.status == ST_OK)
        else $error("spill with error status");

    // Error results report no register.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |->
            !out_data.found && out_data.reg_index == 4'd0)
        else $error("error result carries a register");

    // No result right after reset release without input.
    assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result out of reset");
endmodule

bind register_pool_allocator_fifo_evict rpa_checker u_rpa_checker (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
